>>> hw/rtl/fpf_pkg.sv
// Package for the fractional peak finder: field widths, the ranked peak entry
// type and the frame flush header passed from the core to the output drain.
// No dependencies.
package fpf_pkg;

	localparam int SAMPLE_W = 24;   // Q4.20 sample
	localparam int FRAC_W   = 9;    // unsigned Q1.8 fraction
	localparam int IDX_W    = 11;   // sample index within a frame
	localparam int RANK_W   = 3;    // rank of a reported peak
	localparam int CNT_W    = 4;    // peak count carried to the drain
	localparam int PROD_W   = SAMPLE_W + FRAC_W + 1;

	localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(128);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		sample_t          val;
	} peak_t;

	typedef struct packed {
		logic             load;   // frame ended, list is valid this cycle
		logic [CNT_W-1:0] cnt;    // number of ranked entries
	} flush_t;

endpackage

>>> hw/rtl/fractional_peak_finder_top_n_core.sv
// Top level of the fractional-threshold peak finder with ranked top-N list.
// Instantiates fpf_core and fpf_drain; uses fpf_pkg.
//
//  channel  | valid / stall              | payload
//  ---------+----------------------------+-------------------------------------------
//  sample   | sample_valid / sample_stall| sample, frame_end
//  peak     | peak_valid / peak_stall    | found, rank, peak_index, peak_value, final_item
//  config   | cfg_wr_en (no stall)       | cfg_wr_data -> peak_fraction
//
// One sample beat per cycle is taken while sample_stall is low. A beat is held
// in the input register, where the level update, threshold multiply and sorted
// insert are done in a single pass into the state registers.
// At frame end the list is copied to the drain, which issues up to TOP_N
// result beats (one not-found beat if empty), one a cycle while peak_stall is
// low, via the output register, once the last sample beat has passed the
// input register. sample_stall rises only when a frame-end beat meets a drain
// still holding the previous frame's list; peak_stall holds the output register.
// arst_n clears control state but not data regs; peak_fraction resets to one half (128).
module fractional_peak_finder_top_n_core #(
	parameter int TOP_N     = 2,
	parameter int FRAME_LEN = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fpf_pkg::FRAC_W-1:0]    cfg_wr_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  fpf_pkg::sample_t              sample,
	input  logic                          frame_end,
	output logic                          peak_valid,
	input  logic                          peak_stall,
	output logic                          found,
	output logic [fpf_pkg::RANK_W-1:0]    rank,
	output logic [fpf_pkg::IDX_W-1:0]     peak_index,
	output fpf_pkg::sample_t              peak_value,
	output logic                          final_item
);
	import fpf_pkg::*;

	logic [FRAC_W-1:0] frac_q;

	// input register
	logic    valid_s1;
	sample_t sample_s1;
	logic    frame_end_s1;

	logic   take;
	logic   drain_free;
	flush_t flush;
	peak_t  list [TOP_N];
	peak_t  out_peak;

	assign sample_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q   <= FRAC_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en)
				frac_q <= cfg_wr_data;
			if (!sample_stall)
				valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			sample_s1    <= sample;
			frame_end_s1 <= frame_end;
		end
	end

	fpf_core #(
		.TOP_N     (TOP_N),
		.FRAME_LEN (FRAME_LEN)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.frac        (frac_q),
		.item_valid  (valid_s1),
		.item_sample (sample_s1),
		.item_last   (frame_end_s1),
		.drain_free  (drain_free),
		.take        (take),
		.flush       (flush),
		.list        (list)
	);

	fpf_drain #(
		.TOP_N (TOP_N)
	) u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.flush      (flush),
		.list       (list),
		.drain_free (drain_free),
		.out_stall  (peak_stall),
		.out_valid  (peak_valid),
		.out_peak   (out_peak),
		.out_rank   (rank),
		.out_final  (final_item)
	);

	assign found      = out_peak.found;
	assign peak_index = out_peak.idx;
	assign peak_value = out_peak.val;

endmodule

>>> hw/rtl/fpf_core.sv
// Peak tracking core: running maximum, baseline, thresholds and the ranked
// insert. Uses fpf_pkg.
module fpf_core #(
	parameter int TOP_N     = 2,
	parameter int FRAME_LEN = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fpf_pkg::FRAC_W-1:0]    frac,
	input  logic                          item_valid,
	input  fpf_pkg::sample_t              item_sample,
	input  logic                          item_last,
	input  logic                          drain_free,
	output logic                          take,
	output fpf_pkg::flush_t               flush,
	output fpf_pkg::peak_t                list [TOP_N]
);
	import fpf_pkg::*;

	localparam int CW        = $clog2(TOP_N + 1);
	localparam int IDX_LIM   = (1 << IDX_W) - 1;
	localparam int IDX_MAX_I = (FRAME_LEN - 1 < IDX_LIM) ? FRAME_LEN - 1 : IDX_LIM;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(IDX_MAX_I);
	localparam sample_t S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic [IDX_W-1:0] count_q, count_d;
	sample_t          run_max_q, run_max_d;
	sample_t          left_q, left_d;
	sample_t          thr_q, thr_d;
	logic [IDX_W-1:0] cand_q, cand_d;
	logic             in_peak_q, in_peak_d;
	logic [IDX_W-1:0] rk_idx_q [TOP_N];
	sample_t          rk_val_q [TOP_N];
	logic [CW-1:0]    rk_cnt_q;

	logic [IDX_W-1:0] rk_idx_d [TOP_N];
	sample_t          rk_val_d [TOP_N];
	logic [CW-1:0]    rk_cnt_d;

	logic signed [PROD_W-1:0] prod, left_x256;
	logic signed [PROD_W:0]   rnd;
	sample_t                  thr_sat;
	sample_t                  clamped;
	logic                     do_insert;
	logic                     full, drop;
	logic [CW-1:0]            c_eff;
	logic [TOP_N:0]           bx;    // bx[j+1]: new peak goes at or before slot j

	assign take = item_valid && !(item_last && !drain_free);

	// threshold arithmetic
	assign prod      = $signed({1'b0, frac}) * item_sample;
	assign left_x256 = {{(PROD_W-SAMPLE_W-8){left_q[SAMPLE_W-1]}}, left_q, 8'b0};
	assign rnd       = {prod[PROD_W-1], prod} + (PROD_W+1)'(255);   // ceil(p/256)
	always_comb begin
		if (rnd[PROD_W:SAMPLE_W+7] == '0 || rnd[PROD_W:SAMPLE_W+7] == '1)
			thr_sat = rnd[SAMPLE_W+7:8];
		else
			thr_sat = rnd[PROD_W] ? S_MIN : S_MAX;
	end
	assign clamped = item_sample[SAMPLE_W-1] ? '0 : item_sample;

	// per-sample level update
	always_comb begin
		run_max_d = run_max_q;
		left_d    = left_q;
		thr_d     = thr_q;
		cand_d    = cand_q;
		in_peak_d = in_peak_q;
		do_insert = 1'b0;
		if (count_q == '0) begin
			run_max_d = item_sample;
			left_d    = item_sample;
			thr_d     = '0;
			cand_d    = '0;
			in_peak_d = 1'b0;
		end else if (item_sample > run_max_q) begin
			run_max_d = item_sample;
			if (prod > left_x256) begin
				cand_d    = count_q;
				in_peak_d = 1'b1;
				thr_d     = thr_sat;
			end
		end else if (in_peak_q && item_sample < thr_q) begin
			do_insert = 1'b1;
			in_peak_d = 1'b0;
			run_max_d = clamped;
			left_d    = clamped;
		end else if (!in_peak_q && item_sample < left_q) begin
			run_max_d = clamped;
			left_d    = clamped;
		end
		count_d = (count_q < IDX_MAX) ? count_q + IDX_W'(1) : IDX_MAX;
	end

	// sorted insert of the closing peak (value = running maximum)
	assign full  = rk_cnt_q == CW'(TOP_N);
	assign drop  = full && (rk_val_q[TOP_N-1] > run_max_q);
	assign c_eff = full ? CW'(TOP_N - 1) : rk_cnt_q;

	always_comb begin
		bx[0] = 1'b0;
		for (int j = 0; j < TOP_N; j++)
			bx[j+1] = (CW'(j) >= c_eff) || (rk_val_q[j] < run_max_q);
	end

	always_comb begin
		for (int j = 0; j < TOP_N; j++) begin
			rk_idx_d[j] = rk_idx_q[j];
			rk_val_d[j] = rk_val_q[j];
		end
		rk_cnt_d = rk_cnt_q;
		if (do_insert && !drop) begin
			rk_cnt_d = c_eff + CW'(1);
			if (bx[1]) begin
				rk_idx_d[0] = cand_q;
				rk_val_d[0] = run_max_q;
			end
			for (int j = 1; j < TOP_N; j++) begin
				if (bx[j+1]) begin
					if (bx[j]) begin
						rk_idx_d[j] = rk_idx_q[j-1];
						rk_val_d[j] = rk_val_q[j-1];
					end else begin
						rk_idx_d[j] = cand_q;
						rk_val_d[j] = run_max_q;
					end
				end
			end
		end
	end

	// list as it stands after this sample, for the drain
	always_comb begin
		for (int j = 0; j < TOP_N; j++)
			list[j] = '{found: 1'b1, idx: rk_idx_d[j], val: rk_val_d[j]};
	end
	assign flush.load = take && item_last;
	assign flush.cnt  = CNT_W'(rk_cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			run_max_q <= '0;
			left_q    <= '0;
			thr_q     <= '0;
			cand_q    <= '0;
			in_peak_q <= 1'b0;
			rk_cnt_q  <= '0;
		end else if (take) begin
			if (item_last) begin
				count_q   <= '0;
				run_max_q <= '0;
				left_q    <= '0;
				thr_q     <= '0;
				cand_q    <= '0;
				in_peak_q <= 1'b0;
				rk_cnt_q  <= '0;
			end else begin
				count_q   <= count_d;
				run_max_q <= run_max_d;
				left_q    <= left_d;
				thr_q     <= thr_d;
				cand_q    <= cand_d;
				in_peak_q <= in_peak_d;
				rk_cnt_q  <= rk_cnt_d;
			end
		end
	end

	// list entries: only slots below the count are ever read
	always_ff @(posedge clk) begin
		if (take) begin
			for (int j = 0; j < TOP_N; j++) begin
				rk_idx_q[j] <= rk_idx_d[j];
				rk_val_q[j] <= rk_val_d[j];
			end
		end
	end

endmodule

>>> hw/rtl/fpf_drain.sv
// Output drain: holds a frame's ranked list and issues one result beat per
// cycle while out_stall is low, through the output register. Uses fpf_pkg.
module fpf_drain #(
	parameter int TOP_N = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fpf_pkg::flush_t              flush,
	input  fpf_pkg::peak_t               list [TOP_N],
	output logic                         drain_free,
	input  logic                         out_stall,
	output logic                         out_valid,
	output fpf_pkg::peak_t               out_peak,
	output logic [fpf_pkg::RANK_W-1:0]   out_rank,
	output logic                         out_final
);
	import fpf_pkg::*;

	localparam int CW = $clog2(TOP_N + 1);

	peak_t             pend_q [TOP_N];
	logic [CW-1:0]     pend_cnt_q;
	logic [RANK_W-1:0] rank_q;
	logic              out_valid_q;
	peak_t             out_peak_q;
	logic [RANK_W-1:0] out_rank_q;
	logic              out_final_q;
	logic              pop;

	assign drain_free = pend_cnt_q == '0;
	assign pop        = !drain_free && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q  <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (flush.load) begin
				// empty list still reports one not-found beat
				pend_cnt_q <= (flush.cnt == '0) ? CW'(1) : CW'(flush.cnt);
				rank_q     <= '0;
			end else if (pop) begin
				pend_cnt_q <= pend_cnt_q - CW'(1);
				rank_q     <= rank_q + RANK_W'(1);
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flush.load) begin
			for (int j = 0; j < TOP_N; j++) begin
				if (j == 0 && flush.cnt == '0)
					pend_q[j] <= '0;
				else
					pend_q[j] <= list[j];
			end
		end else if (pop) begin
			for (int j = 0; j < TOP_N - 1; j++)
				pend_q[j] <= pend_q[j+1];
		end
		if (pop) begin
			out_peak_q  <= pend_q[0];
			out_rank_q  <= rank_q;
			out_final_q <= pend_cnt_q == CW'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_peak  = out_peak_q;
	assign out_rank  = out_rank_q;
	assign out_final = out_final_q;

endmodule
